// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: property violated");

// check that a condition never occurs outside reset
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition seen");

`endif

// ===== rtl/mrd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrd_pkg
// Types, constants and codes of the message record deframer.
// ----------------------------------------------------------------------------
package mrd_pkg;

   localparam int BUF_DEPTH = 1024;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);
   localparam int LEN_W     = ADDR_W + 1;
   localparam int HDR_BYTES = 25;
   localparam int HDR_W     = 8 * HDR_BYTES;
   localparam int CNT_W     = $clog2(HDR_BYTES + 1);
   localparam int SUM_W     = 33;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_FINAL  = 2'd1;
   localparam logic [1:0] OP_PARSE  = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_EMPTY  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EVAL,
      ST_CHECK,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } store_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] sender_high;
      logic [63:0] sender_low;
      logic [31:0] record_id;
      logic [7:0]  message_type;
      logic [31:0] body_size;
      logic [9:0]  content_start;
      logic        content_taken;
      logic [7:0]  read_byte;
      logic        overflow;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/mrd_if.sv =====
// ----------------------------------------------------------------------------
// mrd_if
// Valid/ready channels for deframer requests and responses.
// ----------------------------------------------------------------------------
interface mrd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data;
   logic [9:0] read_address;

   modport source (output valid, output operation, output data, output read_address,
                   input ready);
   modport sink   (input valid, input operation, input data, input read_address,
                   output ready);
endinterface

interface mrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] sender_high;
   logic [63:0] sender_low;
   logic [31:0] record_id;
   logic [7:0]  message_type;
   logic [31:0] body_size;
   logic [9:0]  content_start;
   logic        content_taken;
   logic [7:0]  read_byte;
   logic        overflow;
   logic        last;

   modport source (output valid, output kind, output sender_high, output sender_low,
                   output record_id, output message_type, output body_size,
                   output content_start, output content_taken, output read_byte,
                   output overflow, output last, input ready);
   modport sink   (input valid, input kind, input sender_high, input sender_low,
                   input record_id, input message_type, input body_size,
                   input content_start, input content_taken, input read_byte,
                   input overflow, input last, output ready);
endinterface

// ===== rtl/mrd_store.sv =====
// ----------------------------------------------------------------------------
// mrd_store
// Payload byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mrd_store (
   input  logic                   clock,
   input  mrd_pkg::store_req_type req,
   output logic [7:0]             rd_data
);
   import mrd_pkg::*;

   logic [7:0] mem [BUF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data_ff <= mem[req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/message_record_deframer_unit.sv =====
// Responses: an append produces none; a read passes through the store's registered
//   read data and the read state before its response is registered.
// Throughput: appends stream at one byte per cycle while the sequencer idles; a parse
//   walks the store through one read port, record by record, and blocks new requests.
// Reset: synchronous; clears the sequencer, payload length and overflow flag; store
//   contents are not cleared.
// ----------------------------------------------------------------------------
// message_record_deframer_unit
// Buffers payload bytes and cuts them into record descriptors with a sequencer
// around one shared adder/comparator.
// ----------------------------------------------------------------------------
module message_record_deframer_unit (
   input logic            clock,
   input logic            reset,
   mrd_req_if.sink        req_chan,
   mrd_rsp_if.source      rsp_chan
);
   import mrd_pkg::*;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [HDR_W-1:0]  hdr_ff, hdr_in;
   logic              pend_ff, pend_in;
   logic              parse_ff, parse_in;
   logic              oor_ff, oor_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [SUM_W-1:0]  add_a, add_b, sum;
   logic              le_len;
   logic              req_fire, rsp_fire;
   logic [31:0]       size_w;
   logic [7:0]        rd_data;
   store_req_type     store_req;

   mrd_store u_store (
      .clock   (clock),
      .req     (store_req),
      .rd_data (rd_data)
   );

   // shared adder and compare against payload length
   assign sum    = add_a + add_b;
   assign le_len = (sum <= SUM_W'(len_ff));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;

   assign size_w = {hdr_ff[7:0], hdr_ff[15:8], hdr_ff[23:16], hdr_ff[31:24]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.operation)
                  OP_APPEND:          state_in = ST_IDLE;
                  OP_FINAL, OP_PARSE: state_in = ST_CHECK;
                  OP_READ:            state_in = ST_READ;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: begin
            if (cnt_ff == CNT_W'(HDR_BYTES)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL:  state_in = ST_CHECK;
         ST_CHECK: state_in = (pend_ff || !le_len) ? ST_RESP : ST_FETCH;
         ST_READ:  state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_fire) begin
               state_in = rsp_ff.last ? ST_IDLE : ST_FETCH;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      cnt_in       = cnt_ff;
      hdr_in       = hdr_ff;
      pend_in      = pend_ff;
      parse_in     = parse_ff;
      oor_in       = oor_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      add_a        = '0;
      add_b        = '0;
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = len_ff[ADDR_W-1:0];
      store_req.wr_data = req_chan.data;
      store_req.rd_addr = sum[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            store_req.rd_addr = req_chan.read_address[ADDR_W-1:0];
            if (req_fire) begin
               if (req_chan.operation == OP_APPEND || req_chan.operation == OP_FINAL) begin
                  if (len_ff < LEN_W'(BUF_DEPTH)) begin
                     store_req.wr_en = 1'b1;
                     len_in          = len_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               parse_in = (req_chan.operation != OP_READ);
               pos_in   = '0;
               pend_in  = 1'b0;
               oor_in   = ({1'b0, req_chan.read_address} >= 11'(BUF_DEPTH));
            end
         end
         ST_FETCH: begin
            add_a  = SUM_W'(pos_ff);
            add_b  = SUM_W'(cnt_ff);
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0) begin
               hdr_in = {hdr_ff[HDR_W-9:0], rd_data};
            end
         end
         ST_EVAL: begin
            add_a                = SUM_W'(start_ff);
            add_b                = SUM_W'(size_w);
            pos_in               = le_len ? sum[LEN_W-1:0] : start_ff;
            rsp_in.kind          = KIND_RECORD;
            rsp_in.sender_high   = hdr_ff[HDR_W-1 -: 64];
            rsp_in.sender_low    = hdr_ff[HDR_W-65 -: 64];
            rsp_in.record_id     = {hdr_ff[47:40], hdr_ff[55:48], hdr_ff[63:56],
                                    hdr_ff[71:64]};
            rsp_in.message_type  = hdr_ff[39:32];
            rsp_in.body_size     = size_w;
            rsp_in.content_start = 10'(start_ff);
            rsp_in.content_taken = le_len;
            rsp_in.read_byte     = '0;
            rsp_in.overflow      = ovf_ff;
            rsp_in.last          = 1'b0;
            pend_in              = 1'b1;
         end
         ST_CHECK: begin
            add_a    = SUM_W'(pos_ff);
            add_b    = SUM_W'(HDR_BYTES);
            start_in = sum[LEN_W-1:0];
            cnt_in   = '0;
            if (pend_ff) begin
               rsp_in.last  = !le_len;
               rsp_valid_in = 1'b1;
            end else if (!le_len) begin
               rsp_in          = '0;
               rsp_in.kind     = KIND_EMPTY;
               rsp_in.overflow = ovf_ff;
               rsp_in.last     = 1'b1;
               rsp_valid_in    = 1'b1;
            end
         end
         ST_READ: begin
            rsp_in           = '0;
            rsp_in.kind      = KIND_READ;
            rsp_in.read_byte = oor_ff ? 8'd0 : rd_data;
            rsp_in.last      = 1'b1;
            rsp_valid_in     = 1'b1;
         end
         ST_RESP: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               pend_in      = 1'b0;
               cnt_in       = '0;
               if (rsp_ff.last && parse_ff) begin
                  len_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         parse_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         parse_ff     <= parse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      start_ff <= start_in;
      cnt_ff   <= cnt_in;
      hdr_ff   <= hdr_in;
      oor_ff   <= oor_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_ff.kind;
   assign rsp_chan.sender_high   = rsp_ff.sender_high;
   assign rsp_chan.sender_low    = rsp_ff.sender_low;
   assign rsp_chan.record_id     = rsp_ff.record_id;
   assign rsp_chan.message_type  = rsp_ff.message_type;
   assign rsp_chan.body_size     = rsp_ff.body_size;
   assign rsp_chan.content_start = rsp_ff.content_start;
   assign rsp_chan.content_taken = rsp_ff.content_taken;
   assign rsp_chan.read_byte     = rsp_ff.read_byte;
   assign rsp_chan.overflow      = rsp_ff.overflow;
   assign rsp_chan.last          = rsp_ff.last;

`include "assert_macros.svh"

   `ASSERT_NEVER(a_ready_while_pending, clock, reset, req_chan.ready && rsp_valid_ff)
   `ASSERT_CLK(a_len_in_range, clock, reset, len_ff <= LEN_W'(BUF_DEPTH))
   `ASSERT_CLK(a_parse_clears_len, clock, reset,
      (rsp_fire && rsp_ff.last && parse_ff) |=> (len_ff == '0 && !ovf_ff))
   `ASSERT_CLK(a_walk_inside_payload, clock, reset,
      (state_ff == ST_FETCH) |-> (pos_ff <= len_ff))

endmodule

// ===== bench/message_record_deframer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_record_deframer_unit_tb
// Drives byte appends, parse requests and store reads into the deframer and
// checks every response against a cycle-free model of the record walk. The
// sender transfers in random bursts; the receiver stalls in random modes and
// holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module message_record_deframer_unit_tb;
   import mrd_pkg::*;

   localparam int HOLD_CYCLES     = 400;
   localparam int RANDOM_ITEMS    = 210;
   localparam int DRAIN_CYCLES    = 64;
   localparam int MAX_RECORDS     = 40;
   localparam longint RUN_LIMIT_NS = 50_000_000;

   typedef struct {
      logic [1:0] operation;
      logic [7:0] data;
      logic [9:0] read_address;
   } req_item_type;

   typedef enum logic [1:0] {
      RDY_OPEN,
      RDY_PATTERN,
      RDY_COIN
   } ready_mode_type;

   logic clock;
   logic reset;

   mrd_req_if req_chan ();
   mrd_rsp_if rsp_chan ();

   message_record_deframer_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   req_item_type pending_reqs[$];
   rsp_type      expected_rsps[$];
   logic [7:0]   frame_bytes[$];

   // deframer model state
   logic [7:0]  model_store [BUF_DEPTH];
   int unsigned model_len;
   bit          model_ovf;

   // generator-side view of the store fill
   int unsigned gen_len;
   int unsigned gen_fill;

   int             fail_count;
   int             rsp_count;
   int             burst_left;
   int             gap_left;
   int             mode_left;
   int             hold_left;
   bit             hold_done;
   ready_mode_type ready_mode;
   logic [7:0]     stall_pattern;

   // -------------------------------------------------------------------------
   // model
   // -------------------------------------------------------------------------
   function automatic logic [63:0] store_be64(longint unsigned pos);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < 8; i++)
         v = {v[55:0], model_store[(pos + i) % BUF_DEPTH]};
      return v;
   endfunction

   function automatic logic [31:0] store_le32(longint unsigned pos);
      logic [31:0] v;
      v = '0;
      for (int i = 0; i < 4; i++)
         v[8*i +: 8] = model_store[(pos + i) % BUF_DEPTH];
      return v;
   endfunction

   function automatic void predict_parse();
      longint unsigned pos;
      longint unsigned start;
      logic [31:0]     size;
      bit              fits;
      int              n;
      rsp_type         rec;
      rsp_type         held;
      pos = 0;
      n   = 0;
      held = '0;
      while (pos + HDR_BYTES <= model_len && n < MAX_RECORDS) begin
         start = pos + HDR_BYTES;
         size  = store_le32(pos + 21);
         fits  = (start + longint'(size)) <= model_len;
         rec = '0;
         rec.kind          = KIND_RECORD;
         rec.sender_high   = store_be64(pos);
         rec.sender_low    = store_be64(pos + 8);
         rec.record_id     = store_le32(pos + 16);
         rec.message_type  = model_store[(pos + 20) % BUF_DEPTH];
         rec.body_size     = size;
         rec.content_start = start[9:0];
         rec.content_taken = fits;
         rec.overflow      = model_ovf;
         if (n > 0)
            expected_rsps.insert(expected_rsps.size(), held);
         held = rec;
         pos  = fits ? start + size : start;
         n++;
      end
      if (n == 0) begin
         held = '0;
         held.kind     = KIND_EMPTY;
         held.overflow = model_ovf;
      end
      held.last = 1'b1;
      expected_rsps.insert(expected_rsps.size(), held);
      model_len = 0;
      model_ovf = 1'b0;
   endfunction

   function automatic void predict_request(logic [1:0] op, logic [7:0] data,
                                           logic [9:0] addr);
      rsp_type rd;
      if (op == OP_APPEND || op == OP_FINAL) begin
         if (model_len < BUF_DEPTH) begin
            model_store[model_len] = data;
            model_len++;
         end else begin
            model_ovf = 1'b1;
         end
      end
      if (op == OP_FINAL || op == OP_PARSE)
         predict_parse();
      if (op == OP_READ) begin
         rd = '0;
         rd.kind      = KIND_READ;
         rd.read_byte = model_store[addr];
         rd.last      = 1'b1;
         expected_rsps.insert(expected_rsps.size(), rd);
      end
   endfunction

   // -------------------------------------------------------------------------
   // stimulus builders
   // -------------------------------------------------------------------------
   function automatic void queue_byte(logic [7:0] b);
      frame_bytes.insert(frame_bytes.size(), b);
   endfunction

   task automatic push_item(logic [1:0] op, logic [7:0] data, logic [9:0] addr);
      req_item_type it;
      it.operation    = op;
      it.data         = data;
      it.read_address = addr;
      pending_reqs.insert(pending_reqs.size(), it);
      if ((op == OP_APPEND || op == OP_FINAL) && gen_len < BUF_DEPTH) begin
         gen_len++;
         if (gen_len > gen_fill)
            gen_fill = gen_len;
      end
      if (op == OP_FINAL || op == OP_PARSE)
         gen_len = 0;
   endtask

   task automatic add_record(logic [63:0] hi, logic [63:0] lo, logic [31:0] id,
                             logic [7:0] typ, logic [31:0] size, int content_len);
      for (int i = 7; i >= 0; i--)
         queue_byte(hi[8*i +: 8]);
      for (int i = 7; i >= 0; i--)
         queue_byte(lo[8*i +: 8]);
      for (int i = 0; i < 4; i++)
         queue_byte(id[8*i +: 8]);
      queue_byte(typ);
      for (int i = 0; i < 4; i++)
         queue_byte(size[8*i +: 8]);
      for (int i = 0; i < content_len; i++)
         queue_byte(8'($urandom));
   endtask

   // send the collected frame; close it with a final append or a parse
   task automatic send_frame(bit use_final);
      logic [7:0] b;
      bit         closed;
      closed = 1'b0;
      while (frame_bytes.size() > 0) begin
         b = frame_bytes.pop_front();
         if (use_final && frame_bytes.size() == 0) begin
            push_item(OP_FINAL, b, 10'($urandom));
            closed = 1'b1;
         end else begin
            push_item(OP_APPEND, b, 10'($urandom));
         end
      end
      if (!closed)
         push_item(OP_PARSE, 8'($urandom), 10'($urandom));
   endtask

   task automatic push_read(logic [9:0] addr);
      push_item(OP_READ, 8'($urandom), addr);
   endtask

   // -------------------------------------------------------------------------
   // clock and initial values
   // -------------------------------------------------------------------------
   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_APPEND;
      req_chan.data         = '0;
      req_chan.read_address = '0;
      rsp_chan.ready        = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // request driver
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left     <= 1;
         gap_left       <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_request(req_chan.operation, req_chan.data, req_chan.read_address);
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               req_chan.valid <= 1'b0;
               gap_left       <= gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
               req_chan.valid        <= 1'b1;
               req_chan.operation    <= pending_reqs[0].operation;
               req_chan.data         <= pending_reqs[0].data;
               req_chan.read_address <= pending_reqs[0].read_address;
               void'(pending_reqs.pop_front());
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // response ready: random modes and one long hold-off
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         ready_mode     <= RDY_OPEN;
         mode_left      <= 0;
         hold_left      <= 0;
         hold_done      <= 1'b0;
         stall_pattern  <= 8'hA5;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (!hold_done && rsp_count >= 25) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= HOLD_CYCLES;
         hold_done      <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            ready_mode    <= ready_mode_type'($urandom_range(0, 2));
            mode_left     <= $urandom_range(8, 64);
            stall_pattern <= 8'($urandom) | 8'h01;
         end else begin
            mode_left     <= mode_left - 1;
            stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
         end
         case (ready_mode)
            RDY_OPEN:    rsp_chan.ready <= 1'b1;
            RDY_PATTERN: rsp_chan.ready <= stall_pattern[0];
            default:     rsp_chan.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // response monitor
   // -------------------------------------------------------------------------
   task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
         fail_count++;
      end
   endtask

   task automatic check_response();
      rsp_type e;
      e = expected_rsps.pop_front();
      compare_field("kind",          64'(e.kind),          64'(rsp_chan.kind));
      compare_field("sender_high",   e.sender_high,        rsp_chan.sender_high);
      compare_field("sender_low",    e.sender_low,         rsp_chan.sender_low);
      compare_field("record_id",     64'(e.record_id),     64'(rsp_chan.record_id));
      compare_field("message_type",  64'(e.message_type),  64'(rsp_chan.message_type));
      compare_field("body_size",     64'(e.body_size),     64'(rsp_chan.body_size));
      compare_field("content_start", 64'(e.content_start), 64'(rsp_chan.content_start));
      compare_field("content_taken", 64'(e.content_taken), 64'(rsp_chan.content_taken));
      compare_field("read_byte",     64'(e.read_byte),     64'(rsp_chan.read_byte));
      compare_field("overflow",      64'(e.overflow),      64'(rsp_chan.overflow));
      compare_field("last",          64'(e.last),          64'(rsp_chan.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_count <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_count <= rsp_count + 1;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual kind %h", $time,
                     rsp_chan.kind);
            fail_count++;
         end else begin
            check_response();
         end
      end
   end

   // -------------------------------------------------------------------------
   // stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      int unsigned rand_base;
      int          n_rec;
      int          clen;
      int          pick;
      fail_count = 0;
      model_len  = 0;
      model_ovf  = 1'b0;
      gen_len    = 0;
      gen_fill   = 0;

      // empty payload, then a payload shorter than a header
      push_item(OP_PARSE, 8'h00, 10'h3FF);
      queue_byte(8'hFF);
      send_frame(1'b1);
      push_read(10'd0);

      // exact-size record with all-ones header fields apart from a zero body size
      add_record('1, '1, '1, 8'hFF, 32'd0, 0);
      send_frame(1'b1);

      // content too large: walk resumes at the content start
      add_record({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 8'($urandom),
                 32'hFFFF_FFFF, 0);
      add_record('0, '0, '0, 8'h00, 32'd0, 0);
      send_frame(1'b0);

      // fitting content followed by a short tail
      add_record({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 8'($urandom),
                 32'd3, 3);
      for (int i = 0; i < 10; i++)
         queue_byte(8'($urandom));
      send_frame(1'b1);

      // full store: second content starts at the store end, extra bytes drop
      add_record({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 8'($urandom),
                 32'd974, 974);
      add_record({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 8'($urandom),
                 32'd0, 0);
      for (int i = 0; i < 5; i++)
         queue_byte(8'($urandom));
      send_frame(1'b1);
      push_read(10'd1023);
      push_read(10'd512);
      push_read(10'd341);
      push_read(10'd682);
      push_read(10'd0);
      push_item(OP_PARSE, 8'hFF, 10'h000);

      rand_base = pending_reqs.size();
      while (pending_reqs.size() - rand_base < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            n_rec = $urandom_range(1, 3);
            for (int r = 0; r < n_rec; r++) begin
               clen = $urandom_range(0, 6);
               add_record({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                          8'($urandom),
                          ($urandom_range(0, 4) != 0) ? 32'(clen) :
                          ($urandom_range(0, 1) ? 32'(clen + $urandom_range(1, 40))
                                                : 32'($urandom)),
                          clen);
            end
            if ($urandom_range(0, 2) == 0)
               for (int i = $urandom_range(1, 30); i > 0; i--)
                  queue_byte(8'($urandom));
            send_frame(1'($urandom_range(0, 1)));
         end else if (pick < 8) begin
            for (int i = $urandom_range(0, 40); i > 0; i--)
               queue_byte(8'($urandom));
            send_frame(1'($urandom_range(0, 1)));
         end else begin
            for (int i = $urandom_range(1, 4); i > 0; i--)
               push_read(10'($urandom_range(0, gen_fill - 1)));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_chan.valid || expected_rsps.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== message_record_deframer_unit.f =====
+incdir+rtl
rtl/mrd_pkg.sv
rtl/mrd_if.sv
rtl/mrd_store.sv
rtl/message_record_deframer_unit.sv
bench/message_record_deframer_unit_tb.sv
